// ----- sv/asoc_pkg.sv -----
// ----------------------------------------------------------------------------
// asoc_pkg
// Shared constants and types for the array size overflow checker.
// ----------------------------------------------------------------------------
package asoc_pkg;

	// Largest number of dimensions an array may have
	localparam int MAX_DIMS = 32;

	// Dimension counter saturates at MAX_DIMS + 1
	localparam int DCNT_W = $clog2(MAX_DIMS + 2);

	localparam int VAL_W  = 63;   // count and byte total width
	localparam int BND_W  = 64;   // dimension bound width
	localparam int ESZ_W  = 32;   // element size width
	localparam int HALF_W = 32;   // multiplier operand width
	localparam int ACC_W  = 126;  // full width of a 63 x 63 product

	localparam logic [BND_W-1:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// Fixed header: 8 bytes plus 16 bytes per dimension
	localparam logic [VAL_W-1:0] HDR_BASE = 63'd8;
	localparam int HDR_DIM_SHIFT = 4;

	localparam logic [DCNT_W-1:0] DIM_LIMIT = DCNT_W'(MAX_DIMS);

	// One result word
	typedef struct packed {
		logic             ok;
		logic [VAL_W-1:0] element_count;
		logic [VAL_W-1:0] total_bytes;
	} res_t;

endpackage

// ----- sv/asoc_dim_if.sv -----
// ----------------------------------------------------------------------------
// asoc_dim_if
// Dimension channel: one word per array dimension.
// ----------------------------------------------------------------------------
interface asoc_dim_if;
	logic        valid;
	logic        ready;
	logic [63:0] dim_low;
	logic [63:0] dim_high;
	logic        last_dim;

	modport source (output valid, output dim_low, output dim_high, output last_dim,
		input ready);
	modport sink (input valid, input dim_low, input dim_high, input last_dim,
		output ready);
endinterface

// ----- sv/asoc_res_if.sv -----
// ----------------------------------------------------------------------------
// asoc_res_if
// Result channel: one word per completed array.
// ----------------------------------------------------------------------------
interface asoc_res_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [62:0] element_count;
	logic [62:0] total_bytes;

	modport source (output valid, output ok, output element_count,
		output total_bytes, input ready);
	modport sink (input valid, input ok, input element_count,
		input total_bytes, output ready);
endinterface

// ----- sv/asoc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// asoc_cfg_if
// Configuration write channel carrying the element size.
// ----------------------------------------------------------------------------
interface asoc_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/asoc_mul.sv -----
// ----------------------------------------------------------------------------
// asoc_mul
// Shared 32 x 32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module asoc_mul (
	input  logic                           clk,
	input  logic                           en,
	input  logic [asoc_pkg::HALF_W-1:0]    a,
	input  logic [asoc_pkg::HALF_W-1:0]    b,
	output logic [2*asoc_pkg::HALF_W-1:0]  prod_s1
);

	// Register one partial product per issue
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (2*asoc_pkg::HALF_W)'(a) * (2*asoc_pkg::HALF_W)'(b);
		end
	end

endmodule

// ----- sv/asoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// asoc_ctrl
// Sequencer: span check, running count product and total byte check, all
// multiplies going through one shared 32 x 32 unit as partial products.
// ----------------------------------------------------------------------------
module asoc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	asoc_dim_if.sink                    dim,
	input  logic [asoc_pkg::ESZ_W-1:0]  el_bytes,
	output logic                        res_valid,
	input  logic                        res_free,
	output asoc_pkg::res_t              res_word
);

	typedef enum logic [2:0] {
		S_IDLE, S_SPAN, S_MUL, S_CHK, S_TOT, S_EMIT
	} state_t;

	state_t state_q;

	logic [asoc_pkg::BND_W-1:0]  lo_q, hi_q;
	logic                        last_q;
	logic [asoc_pkg::VAL_W-1:0]  count_q;
	logic                        zero_q, fail_q;
	logic [asoc_pkg::DCNT_W-1:0] dcnt_q;
	logic [asoc_pkg::ACC_W-1:0]  acc_q;
	logic [asoc_pkg::VAL_W-1:0]  opb_q;
	logic                        tot_q;
	logic [2:0]                  step_q;
	logic [1:0]                  sum_s1;
	asoc_pkg::res_t              res_q;

	logic [asoc_pkg::DCNT_W-1:0] dcnt_nxt;
	logic                        fail_nxt;
	logic                        lo_gt_hi;
	logic [asoc_pkg::BND_W-1:0]  diff;
	logic                        span_big;
	logic [asoc_pkg::VAL_W-1:0]  header;
	logic [2:0]                  npp;
	logic                        ia, ib;
	logic                        issue;
	logic [asoc_pkg::HALF_W-1:0] mul_a, mul_b;
	logic [2*asoc_pkg::HALF_W-1:0] prod_s1;
	logic [asoc_pkg::ACC_W-1:0]  pp_ext;
	logic                        acc_ovf;

	// Dimension bookkeeping and span of the held word
	always_comb begin
		dcnt_nxt = (dcnt_q <= asoc_pkg::DIM_LIMIT) ? dcnt_q + 1'b1 : dcnt_q;
		fail_nxt = fail_q | (dcnt_nxt > asoc_pkg::DIM_LIMIT);
		lo_gt_hi = $signed(lo_q) > $signed(hi_q);
		diff     = hi_q - lo_q;
		span_big = diff >= asoc_pkg::I64_MAX;
		header   = asoc_pkg::HDR_BASE
			+ (asoc_pkg::VAL_W'(dcnt_q) << asoc_pkg::HDR_DIM_SHIFT);
	end

	// Partial product selection: four for count * span, two for count * size
	always_comb begin
		npp   = tot_q ? 3'd2 : 3'd4;
		ia    = tot_q ? step_q[0] : step_q[1];
		ib    = tot_q ? 1'b0 : step_q[0];
		issue = (state_q == S_MUL) && (step_q < npp);
		mul_a = ia ? {1'b0, count_q[asoc_pkg::VAL_W-1:asoc_pkg::HALF_W]}
			: count_q[asoc_pkg::HALF_W-1:0];
		mul_b = ib ? {1'b0, opb_q[asoc_pkg::VAL_W-1:asoc_pkg::HALF_W]}
			: opb_q[asoc_pkg::HALF_W-1:0];
	end

	asoc_mul u_mul (
		.clk     (clk),
		.en      (issue),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	// Align the registered partial product to its weight
	always_comb begin
		case (sum_s1)
			2'd0:    pp_ext = asoc_pkg::ACC_W'(prod_s1);
			2'd1:    pp_ext = asoc_pkg::ACC_W'(prod_s1) << asoc_pkg::HALF_W;
			default: pp_ext = asoc_pkg::ACC_W'(prod_s1) << (2*asoc_pkg::HALF_W);
		endcase
		acc_ovf = |acc_q[asoc_pkg::ACC_W-1:asoc_pkg::VAL_W];
	end

	assign dim.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT);
	assign res_word  = res_q;

	// Sequencer state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lo_q    <= '0;
			hi_q    <= '0;
			last_q  <= 1'b0;
			count_q <= asoc_pkg::VAL_W'(1);
			zero_q  <= 1'b0;
			fail_q  <= 1'b0;
			dcnt_q  <= '0;
			acc_q   <= '0;
			opb_q   <= '0;
			tot_q   <= 1'b0;
			step_q  <= '0;
			sum_s1  <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (dim.valid) begin
						lo_q    <= dim.dim_low;
						hi_q    <= dim.dim_high;
						last_q  <= dim.last_dim;
						state_q <= S_SPAN;
					end
				end
				S_SPAN: begin
					dcnt_q <= dcnt_nxt;
					fail_q <= fail_nxt;
					if (fail_nxt || zero_q) begin
						state_q <= last_q ? S_TOT : S_IDLE;
					end else if (lo_gt_hi) begin
						zero_q  <= 1'b1;
						count_q <= '0;
						state_q <= last_q ? S_TOT : S_IDLE;
					end else if (span_big) begin
						fail_q  <= 1'b1;
						state_q <= last_q ? S_TOT : S_IDLE;
					end else begin
						opb_q   <= diff[asoc_pkg::VAL_W-1:0] + 1'b1;
						acc_q   <= '0;
						tot_q   <= 1'b0;
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// Issue one partial product, fold in the previous one
					sum_s1 <= {1'b0, ia} + {1'b0, ib};
					if (step_q != 3'd0) begin
						acc_q <= acc_q + pp_ext;
					end
					if (step_q == npp) begin
						state_q <= S_CHK;
					end
					step_q <= step_q + 1'b1;
				end
				S_CHK: begin
					if (tot_q) begin
						if (acc_ovf) begin
							res_q <= '0;
						end else begin
							res_q.ok            <= 1'b1;
							res_q.element_count <= count_q;
							res_q.total_bytes   <= acc_q[asoc_pkg::VAL_W-1:0];
						end
						state_q <= S_EMIT;
					end else begin
						if (acc_ovf) begin
							fail_q <= 1'b1;
						end else begin
							count_q <= acc_q[asoc_pkg::VAL_W-1:0];
						end
						state_q <= last_q ? S_TOT : S_IDLE;
					end
				end
				S_TOT: begin
					if (fail_q || (el_bytes == '0)) begin
						res_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						acc_q   <= asoc_pkg::ACC_W'(header);
						opb_q   <= asoc_pkg::VAL_W'(el_bytes);
						tot_q   <= 1'b1;
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_EMIT: begin
					// Hand off the result, then clear the array state
					if (res_free) begin
						count_q <= asoc_pkg::VAL_W'(1);
						zero_q  <= 1'b0;
						fail_q  <= 1'b0;
						dcnt_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/array_size_overflow_checker_top.sv -----
// Input: a dimension word is taken only while the sequencer is idle, so a new word
// waits until the previous one's span check and any multiply (four partial products on
// the shared 32 x 32 unit) are done; after the last word the input stays closed until
// the result enters the output slot.
// Reset: arst_n clears the array state and the output slot; element size is 1.
// ----------------------------------------------------------------------------
// array_size_overflow_checker_top
// Top level: element size register, result output register and sequencer.
// ----------------------------------------------------------------------------
module array_size_overflow_checker_top (
	input  logic         clk,
	input  logic         arst_n,
	asoc_dim_if.sink     dim,
	asoc_res_if.source   res,
	asoc_cfg_if.sink     cfg
);

	logic [asoc_pkg::ESZ_W-1:0] el_bytes_q;
	logic                       out_valid_q;
	asoc_pkg::res_t             out_q;
	logic                       res_valid;
	logic                       res_free;
	asoc_pkg::res_t             res_word;

	asoc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.dim       (dim),
		.el_bytes  (el_bytes_q),
		.res_valid (res_valid),
		.res_free  (res_free),
		.res_word  (res_word)
	);

	// Hold the element size
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			el_bytes_q <= asoc_pkg::ESZ_W'(1);
		end else if (cfg.valid) begin
			el_bytes_q <= cfg.data;
		end
	end

	// Output slot: take a new word when empty or being drained
	assign res_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_q <= res_word;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.ok            = out_q.ok;
	assign res.element_count = out_q.element_count;
	assign res.total_bytes   = out_q.total_bytes;

endmodule
